### src/stas_pkg.sv
package stas_pkg;

  // fixed formats
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 14;
  localparam int ANG_W           = 16;
  localparam int PULSE_W         = 12;
  localparam int DB_W            = 10;
  localparam int LIM_W           = 15;
  localparam int CFG_DATA_W      = 15;
  localparam int CFG_IDX_W       = 2;
  localparam int FUNC_W          = 2;

  // event kinds
  localparam logic [FUNC_W-1:0] FUNC_NAV      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TAKEOVER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT  = 2'd2;

  localparam logic [PULSE_W-1:0] CENTER_RST = 12'd1500;
  localparam logic [DB_W-1:0]    DB_RST     = 10'd50;
  localparam logic [LIM_W-1:0]   LIM_RST    = 15'd8579;

  // stick scaling: q = floor((mag * 2^F + 2500) / 5000) via reciprocal
  localparam int STICK_SCALE = 5000;
  localparam int STICK_HALF  = STICK_SCALE / 2;
  localparam int NW          = PULSE_W + ANGLE_FRAC_BITS + 1;
  localparam int RECIP_SHIFT = NW;
  localparam int RECIP       = (2 ** NW) / STICK_SCALE;
  localparam int QW          = NW - PULSE_W;
  localparam int STEP_W      = 16;

  // CORDIC, Q30
  localparam int  ZW           = ANG_W + 30 - ANGLE_FRAC_BITS + 1;
  localparam int  XW           = 32;
  localparam int  CIW          = $clog2(CORDIC_STEPS);
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN    = 64'sd652032874;

  // shared multiplier
  localparam int MA_W = 32;
  localparam int MB_W = 16;
  localparam int PW   = MA_W + MB_W;
  localparam int DW   = PW - 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_RND,
    ST_FIN
  } ctl_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_WRAP,
    CS_FOLD,
    CS_ITER,
    CS_DONE
  } cordic_state_t;

  typedef enum logic [3:0] {
    OP_E_EST,
    OP_E_FIX,
    OP_R_EST,
    OP_R_FIX,
    OP_A_EST,
    OP_A_FIX,
    OP_CE,
    OP_SR,
    OP_CR,
    OP_SE
  } mul_op_t;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] sin_q;
    logic signed [XW-1:0] cos_q;
  } cordic_res_t;

  function automatic logic signed [31:0] atan_entry(input logic [3:0] idx);
    logic signed [31:0] v;
    case (idx)
      4'd0:    v = 32'sd843314856;
      4'd1:    v = 32'sd497837829;
      4'd2:    v = 32'sd263043836;
      4'd3:    v = 32'sd133525158;
      4'd4:    v = 32'sd67021686;
      4'd5:    v = 32'sd33543515;
      4'd6:    v = 32'sd16775850;
      4'd7:    v = 32'sd8388437;
      4'd8:    v = 32'sd4194282;
      4'd9:    v = 32'sd2097149;
      4'd10:   v = 32'sd1048575;
      4'd11:   v = 32'sd524287;
      4'd12:   v = 32'sd262143;
      4'd13:   v = 32'sd131071;
      4'd14:   v = 32'sd65535;
      default: v = 32'sd32767;
    endcase
    return v;
  endfunction

endpackage

### src/stas_in_if.sv
interface stas_in_if import stas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [ANG_W-1:0] roll_angle;
  logic signed [ANG_W-1:0] pitch_angle;
  logic [PULSE_W-1:0]      elevator_pulse;
  logic [PULSE_W-1:0]      rudder_pulse;
  logic [PULSE_W-1:0]      aileron_pulse;

  modport source (
    output valid, func, roll_angle, pitch_angle, elevator_pulse, rudder_pulse,
           aileron_pulse,
    input  ready
  );
  modport sink (
    input  valid, func, roll_angle, pitch_angle, elevator_pulse, rudder_pulse,
           aileron_pulse,
    output ready
  );
endinterface

### src/stas_out_if.sv
interface stas_out_if import stas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] pitch_target;
  logic signed [ANG_W-1:0] roll_target;
  logic signed [ANG_W-1:0] yaw_target;
  logic                    controller_enabled;
  logic                    controller_reset;

  modport source (
    output valid, pitch_target, roll_target, yaw_target, controller_enabled,
           controller_reset,
    input  ready
  );
  modport sink (
    input  valid, pitch_target, roll_target, yaw_target, controller_enabled,
           controller_reset,
    output ready
  );
endinterface

### src/stas_cfg_if.sv
interface stas_cfg_if import stas_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/stas_mul.sv
module stas_mul import stas_pkg::*; (
  input  logic                 clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [PW-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

### src/stas_cordic.sv
module stas_cordic import stas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output cordic_res_t             res
);

  localparam logic signed [ZW-1:0] PI_Z      = ZW'(Q30_PI);
  localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(Q30_TWO_PI);
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(Q30_HALF_PI);
  localparam logic signed [XW-1:0] GAIN_X    = XW'(Q30_GAIN);
  localparam logic [CIW-1:0]       I_LAST    = CIW'(CORDIC_STEPS - 1);

  cordic_state_t          state_r, state_nxt;
  logic signed [ZW-1:0]   z_r, z_nxt;
  logic signed [XW-1:0]   x_r, x_nxt;
  logic signed [XW-1:0]   y_r, y_nxt;
  logic                   neg_r, neg_nxt;
  logic [CIW-1:0]         i_r, i_nxt;
  logic signed [ZW-1:0]   z_start;
  logic signed [XW-1:0]   x_sh, y_sh;
  logic signed [ZW-1:0]   at_z;

  // Q(F) to Q30, sign extended
  assign z_start = {{(ZW-ANG_W){angle[ANG_W-1]}}, angle} <<< (30 - ANGLE_FRAC_BITS);
  assign x_sh    = x_r >>> i_r;
  assign y_sh    = y_r >>> i_r;
  assign at_z    = ZW'(atan_entry(4'(i_r)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE, CS_DONE: begin
        if (start) state_nxt = CS_WRAP;
      end
      CS_WRAP: state_nxt = CS_FOLD;
      CS_FOLD: state_nxt = CS_ITER;
      CS_ITER: begin
        if (i_r == I_LAST) state_nxt = CS_DONE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    z_nxt   = z_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    neg_nxt = neg_r;
    i_nxt   = i_r;
    case (state_r)
      CS_IDLE, CS_DONE: begin
        if (start) begin
          z_nxt = z_start;
          x_nxt = GAIN_X;
          y_nxt = '0;
          i_nxt = '0;
        end
      end
      CS_WRAP: begin
        if (z_r > PI_Z) z_nxt = z_r - TWO_PI_Z;
        else if (z_r <= -PI_Z) z_nxt = z_r + TWO_PI_Z;
      end
      CS_FOLD: begin
        neg_nxt = 1'b0;
        if (z_r > HALF_PI_Z) begin
          z_nxt   = z_r - PI_Z;
          neg_nxt = 1'b1;
        end else if (z_r < -HALF_PI_Z) begin
          z_nxt   = z_r + PI_Z;
          neg_nxt = 1'b1;
        end
      end
      CS_ITER: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - at_z;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + at_z;
        end
        i_nxt = i_r + CIW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    res.done  = (state_r == CS_DONE);
    res.sin_q = neg_r ? -y_r : y_r;
    res.cos_q = neg_r ? -x_r : x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    z_r   <= z_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
    i_r   <= i_nxt;
  end

endmodule

### src/stick_to_attitude_setpoint_core.sv
// Stick to attitude setpoint core.
// in_chan carries one event per transaction: navigate step, takeover or
// release, with measured roll/pitch and the three raw stick pulses.
// out_chan returns exactly one result transaction per event: pitch, roll
// and yaw-rate setpoints plus controller enable and reset flags.
// cfg_chan writes servo_center, dead_band and angle_limit; it is always
// ready and must only be used while no event is in flight.
// Navigate: one shared 32x16 multiplier runs ten operations (stick scaling,
// then the roll rotation), each a multiply step and a write-back step, and
// waits on the CORDIC sine/cosine sequencer for the rotation products.
// Takeover, release and unused codes go from idle straight to the final step.
// in_chan.ready is high only while the sequencer is idle. The result sits
// in an output register, so a new event is taken while it waits; if the
// receiver stalls, the next result holds in the final step until the
// register frees up.
// Reset (rst_n low, synchronous) clears setpoints, disables the controller,
// drops out_chan.valid and restores the register defaults.
module stick_to_attitude_setpoint_core import stas_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  stas_in_if.sink    in_chan,
  stas_out_if.source out_chan,
  stas_cfg_if.sink   cfg_chan
);

  localparam int SW = DW + 1;
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sd1 <<< 29);
  localparam logic signed [DW-1:0] YAW_MAX = DW'(32767);
  localparam logic signed [DW-1:0] YAW_MIN = DW'(-32768);

  ctl_state_t                   state_r, state_nxt;
  mul_op_t                      op_r, op_nxt;
  logic [PULSE_W-1:0]           center_r, center_nxt;
  logic [DB_W-1:0]              db_r, db_nxt;
  logic [LIM_W-1:0]             lim_r, lim_nxt;
  logic [FUNC_W-1:0]            func_r, func_nxt;
  logic signed [ANG_W-1:0]      roll_r, roll_nxt;
  logic signed [ANG_W-1:0]      pitch_r, pitch_nxt;
  logic [2:0][PULSE_W-1:0]      mag_r, mag_nxt;
  logic [2:0]                   neg_r, neg_nxt;
  logic [2:0]                   dz_r, dz_nxt;
  logic [QW-1:0]                qe_r, qe_nxt;
  logic [2:0][STEP_W-1:0]       step_r, step_nxt;
  logic signed [PW-1:0]         acc_dp_r, acc_dp_nxt;
  logic signed [PW-1:0]         acc_yw_r, acc_yw_nxt;
  logic signed [DW-1:0]         dp_r, dp_nxt;
  logic signed [DW-1:0]         yw_r, yw_nxt;
  logic signed [ANG_W-1:0]      pitch_set_r, pitch_set_nxt;
  logic signed [ANG_W-1:0]      roll_set_r, roll_set_nxt;
  logic signed [ANG_W-1:0]      yaw_set_r, yaw_set_nxt;
  logic                         en_r, en_nxt;
  logic signed [ANG_W-1:0]      out_pitch_r, out_pitch_nxt;
  logic signed [ANG_W-1:0]      out_roll_r, out_roll_nxt;
  logic signed [ANG_W-1:0]      out_yaw_r, out_yaw_nxt;
  logic                         out_en_r, out_en_nxt;
  logic                         out_rst_r, out_rst_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         in_acc, cfg_acc, out_free;
  logic                         in_ready_c, cordic_start, fin_load;
  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [PW-1:0]         mul_p;
  cordic_res_t                  cres;
  logic [2:0][PULSE_W-1:0]      pulse_in;
  logic [1:0]                   kk;
  logic [NW-1:0]                n_sel;
  logic [NW-1:0]                r_v;
  logic [QW-1:0]                q_v;
  logic [STEP_W-1:0]            step_v;
  logic signed [PW-1:0]         rnd_dp, rnd_yw;
  logic signed [SW-1:0]         pitch_sum, roll_sum, lim_p, lim_n;

  stas_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  stas_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (in_chan.roll_angle),
    .res   (cres)
  );

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign cfg_acc  = cfg_chan.valid && cfg_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign pulse_in = {in_chan.aileron_pulse, in_chan.rudder_pulse, in_chan.elevator_pulse};

  // stick element handled by the current scaling op
  assign kk    = op_r[2:1];
  assign n_sel = {1'b0, mag_r[kk], {ANGLE_FRAC_BITS{1'b0}}} + NW'(STICK_HALF);
  // estimate is at most one short
  assign r_v    = n_sel - mul_p[NW-1:0];
  assign q_v    = (r_v >= NW'(STICK_SCALE)) ? qe_r + QW'(1) : qe_r;
  assign step_v = dz_r[kk] ? '0 :
                  (neg_r[kk] ? STEP_W'(0) - STEP_W'(q_v) : STEP_W'(q_v));

  assign rnd_dp    = acc_dp_r + ROUND_HALF;
  assign rnd_yw    = acc_yw_r + ROUND_HALF;
  assign pitch_sum = SW'(pitch_set_r) + SW'(dp_r);
  assign roll_sum  = SW'(roll_set_r) + SW'($signed(step_r[2]));
  assign lim_p     = SW'({1'b0, lim_r});
  assign lim_n     = -lim_p;

  assign in_chan.ready              = in_ready_c;
  assign cfg_chan.ready             = 1'b1;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.pitch_target      = out_pitch_r;
  assign out_chan.roll_target       = out_roll_r;
  assign out_chan.yaw_target        = out_yaw_r;
  assign out_chan.controller_enabled = out_en_r;
  assign out_chan.controller_reset  = out_rst_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = (in_chan.func == FUNC_NAV) ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        if (!(op_r == OP_CE && !cres.done)) state_nxt = ST_WB;
      end
      ST_WB:   state_nxt = (op_r == OP_SE) ? ST_RND : ST_MUL;
      ST_RND:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_c   = (state_r == ST_IDLE);
    cordic_start = in_acc && (in_chan.func == FUNC_NAV);
    fin_load     = (state_r == ST_FIN) && out_free;
    mul_a        = '0;
    mul_b        = '0;
    if (state_r == ST_MUL) begin
      case (op_r)
        OP_E_EST, OP_R_EST, OP_A_EST: begin
          mul_a = MA_W'(n_sel);
          mul_b = MB_W'(RECIP);
        end
        OP_E_FIX, OP_R_FIX, OP_A_FIX: begin
          mul_a = MA_W'(qe_r);
          mul_b = MB_W'(STICK_SCALE);
        end
        OP_CE: begin
          mul_a = cres.cos_q;
          mul_b = $signed(step_r[0]);
        end
        OP_SR: begin
          mul_a = cres.sin_q;
          mul_b = $signed(step_r[1]);
        end
        OP_CR: begin
          mul_a = cres.cos_q;
          mul_b = $signed(step_r[1]);
        end
        OP_SE: begin
          mul_a = cres.sin_q;
          mul_b = $signed(step_r[0]);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    logic signed [PULSE_W:0] d_v;
    d_v           = '0;
    center_nxt    = center_r;
    db_nxt        = db_r;
    lim_nxt       = lim_r;
    func_nxt      = func_r;
    roll_nxt      = roll_r;
    pitch_nxt     = pitch_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    dz_nxt        = dz_r;
    op_nxt        = op_r;
    qe_nxt        = qe_r;
    step_nxt      = step_r;
    acc_dp_nxt    = acc_dp_r;
    acc_yw_nxt    = acc_yw_r;
    dp_nxt        = dp_r;
    yw_nxt        = yw_r;
    pitch_set_nxt = pitch_set_r;
    roll_set_nxt  = roll_set_r;
    yaw_set_nxt   = yaw_set_r;
    en_nxt        = en_r;
    out_pitch_nxt = out_pitch_r;
    out_roll_nxt  = out_roll_r;
    out_yaw_nxt   = out_yaw_r;
    out_en_nxt    = out_en_r;
    out_rst_nxt   = out_rst_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    if (cfg_acc) begin
      case (cfg_chan.index)
        CFG_SERVO_CENTER: center_nxt = cfg_chan.data[PULSE_W-1:0];
        CFG_DEAD_BAND:    db_nxt     = cfg_chan.data[DB_W-1:0];
        CFG_ANGLE_LIMIT:  lim_nxt    = cfg_chan.data[LIM_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_chan.func;
          roll_nxt  = in_chan.roll_angle;
          pitch_nxt = in_chan.pitch_angle;
          op_nxt    = OP_E_EST;
          for (int k = 0; k < 3; k++) begin
            d_v        = $signed({1'b0, pulse_in[k]}) - $signed({1'b0, center_r});
            neg_nxt[k] = d_v[PULSE_W];
            mag_nxt[k] = d_v[PULSE_W] ? PULSE_W'(-d_v) : d_v[PULSE_W-1:0];
            dz_nxt[k]  = (mag_nxt[k] < {{(PULSE_W-DB_W){1'b0}}, db_r});
          end
        end
      end
      ST_WB: begin
        case (op_r)
          OP_E_EST, OP_R_EST, OP_A_EST: qe_nxt = mul_p[RECIP_SHIFT +: QW];
          OP_E_FIX, OP_R_FIX, OP_A_FIX: step_nxt[kk] = step_v;
          OP_CE: acc_dp_nxt = -mul_p;
          OP_SR: acc_dp_nxt = acc_dp_r - mul_p;
          OP_CR: acc_yw_nxt = mul_p;
          OP_SE: acc_yw_nxt = acc_yw_r - mul_p;
          default: ;
        endcase
        if (op_r != OP_SE) op_nxt = mul_op_t'(op_r + 4'd1);
      end
      ST_RND: begin
        // round half up, Q(F+30) to Q(F)
        dp_nxt = rnd_dp[30 +: DW];
        yw_nxt = rnd_yw[30 +: DW];
      end
      ST_FIN: begin
        if (fin_load) begin
          out_rst_nxt = 1'b0;
          case (func_r)
            FUNC_NAV: begin
              if (pitch_sum > lim_p)      pitch_set_nxt = ANG_W'(lim_p);
              else if (pitch_sum < lim_n) pitch_set_nxt = ANG_W'(lim_n);
              else                        pitch_set_nxt = ANG_W'(pitch_sum);
              if (roll_sum > lim_p)       roll_set_nxt = ANG_W'(lim_p);
              else if (roll_sum < lim_n)  roll_set_nxt = ANG_W'(lim_n);
              else                        roll_set_nxt = ANG_W'(roll_sum);
              if (yw_r > YAW_MAX)         yaw_set_nxt = ANG_W'(YAW_MAX);
              else if (yw_r < YAW_MIN)    yaw_set_nxt = ANG_W'(YAW_MIN);
              else                        yaw_set_nxt = ANG_W'(yw_r);
            end
            FUNC_TAKEOVER: begin
              // measured attitude loads unsaturated
              pitch_set_nxt = pitch_r;
              roll_set_nxt  = roll_r;
              yaw_set_nxt   = '0;
              en_nxt        = 1'b1;
              out_rst_nxt   = 1'b1;
            end
            FUNC_RELEASE: en_nxt = 1'b0;
            default: ;
          endcase
          out_pitch_nxt = pitch_set_nxt;
          out_roll_nxt  = roll_set_nxt;
          out_yaw_nxt   = yaw_set_nxt;
          out_en_nxt    = en_nxt;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_E_EST;
      center_r    <= CENTER_RST;
      db_r        <= DB_RST;
      lim_r       <= LIM_RST;
      pitch_set_r <= '0;
      roll_set_r  <= '0;
      yaw_set_r   <= '0;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      center_r    <= center_nxt;
      db_r        <= db_nxt;
      lim_r       <= lim_nxt;
      pitch_set_r <= pitch_set_nxt;
      roll_set_r  <= roll_set_nxt;
      yaw_set_r   <= yaw_set_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r      <= func_nxt;
    roll_r      <= roll_nxt;
    pitch_r     <= pitch_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    dz_r        <= dz_nxt;
    qe_r        <= qe_nxt;
    step_r      <= step_nxt;
    acc_dp_r    <= acc_dp_nxt;
    acc_yw_r    <= acc_yw_nxt;
    dp_r        <= dp_nxt;
    yw_r        <= yw_nxt;
    out_pitch_r <= out_pitch_nxt;
    out_roll_r  <= out_roll_nxt;
    out_yaw_r   <= out_yaw_nxt;
    out_en_r    <= out_en_nxt;
    out_rst_r   <= out_rst_nxt;
  end

endmodule

### src/stas_checker.sv
module stas_checker import stas_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ANG_W-1:0] out_pitch,
  input logic signed [ANG_W-1:0] out_roll,
  input logic signed [ANG_W-1:0] out_yaw,
  input logic                    out_en,
  input logic                    out_rst
);

  // one event at a time: busy straight after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch) && $stable(out_roll)
      && $stable(out_yaw) && $stable(out_en) && $stable(out_rst))
    else $error("stalled result changed");

  a_reset_enables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rst |-> out_en)
    else $error("controller reset without enable");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stick_to_attitude_setpoint_core stas_checker u_stas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_pitch (out_chan.pitch_target),
  .out_roll  (out_chan.roll_target),
  .out_yaw   (out_chan.yaw_target),
  .out_en    (out_chan.controller_enabled),
  .out_rst   (out_chan.controller_reset)
);

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stas_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_PER_SETTING = 80;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic [PULSE_W-1:0]      elevator_pulse;
    logic [PULSE_W-1:0]      rudder_pulse;
    logic [PULSE_W-1:0]      aileron_pulse;
  } stick_event_t;

  typedef struct {
    logic signed [ANG_W-1:0] pitch_target;
    logic signed [ANG_W-1:0] roll_target;
    logic signed [ANG_W-1:0] yaw_target;
    logic                    controller_enabled;
    logic                    controller_reset;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // testbench-side drive registers, known from time zero
  logic                    in_valid = 1'b0;
  logic [FUNC_W-1:0]       in_func = FUNC_NAV;
  logic signed [ANG_W-1:0] in_roll = '0;
  logic signed [ANG_W-1:0] in_pitch = '0;
  logic [PULSE_W-1:0]      in_elev = '0;
  logic [PULSE_W-1:0]      in_rud = '0;
  logic [PULSE_W-1:0]      in_ail = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_SERVO_CENTER;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  stas_in_if  in_if ();
  stas_out_if out_if ();
  stas_cfg_if cfg_if ();

  assign in_if.valid          = in_valid;
  assign in_if.func           = in_func;
  assign in_if.roll_angle     = in_roll;
  assign in_if.pitch_angle    = in_pitch;
  assign in_if.elevator_pulse = in_elev;
  assign in_if.rudder_pulse   = in_rud;
  assign in_if.aileron_pulse  = in_ail;
  assign out_if.ready         = out_ready;
  assign cfg_if.valid         = cfg_valid;
  assign cfg_if.index         = cfg_index;
  assign cfg_if.data          = cfg_data;

  stick_to_attitude_setpoint_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // predictor state and register copies
  longint             pitch_sp = 0;
  longint             roll_sp = 0;
  longint             yaw_sp = 0;
  bit                 ctrl_en = 1'b0;
  logic [PULSE_W-1:0] center_cfg = CENTER_RST;
  logic [DB_W-1:0]    dband_cfg = DB_RST;
  logic [LIM_W-1:0]   limit_cfg = LIM_RST;

  stick_event_t event_q[$];
  setpoint_t    setpoint_q[$];

  int error_count = 0;
  int checked_count = 0;
  int nav_count = 0;
  int takeover_count = 0;
  int release_count = 0;
  int unused_count = 0;
  int settings_count = 1;

  task automatic report_error(string msg);
    if (error_count < MAX_PRINTED)
      $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // centre offset, dead band, then counts to Q13 radians rounded half up
  function automatic longint stick_to_rad(logic [PULSE_W-1:0] pulse);
    longint d, mag;
    d = longint'(pulse) - longint'(center_cfg);
    if (d > -longint'(dband_cfg) && d < longint'(dband_cfg))
      return 0;
    mag = (d < 0) ? -d : d;
    mag = (mag * (longint'(1) << ANGLE_FRAC_BITS) + STICK_HALF) / STICK_SCALE;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic longint atan_q30(int i);
    case (i)
      0:       return 843314856;
      1:       return 497837829;
      2:       return 263043836;
      3:       return 133525158;
      4:       return 67021686;
      5:       return 33543515;
      6:       return 16775850;
      7:       return 8388437;
      8:       return 4194282;
      9:       return 2097149;
      10:      return 1048575;
      11:      return 524287;
      12:      return 262143;
      13:      return 131071;
      14:      return 65535;
      default: return 32767;
    endcase
  endfunction

  function automatic void roll_sin_cos(input logic signed [ANG_W-1:0] ang,
                                       output longint s, output longint c);
    longint z, x, y, t;
    bit flip;
    int n;
    z = longint'(ang) * (longint'(1) << (30 - ANGLE_FRAC_BITS));
    x = Q30_GAIN;
    y = 0;
    flip = 1'b0;
    for (n = 0; n < 16 && z > Q30_PI; n++)
      z -= Q30_TWO_PI;
    for (n = 0; n < 16 && z <= -Q30_PI; n++)
      z += Q30_TWO_PI;
    // fold into the right half plane; sine and cosine change sign
    if (z > Q30_HALF_PI) begin
      z -= Q30_PI;
      flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      z += Q30_PI;
      flip = 1'b1;
    end
    for (n = 0; n < CORDIC_STEPS && n < 16; n++) begin
      if (z >= 0) begin
        t = x - (y >>> n);
        y = y + (x >>> n);
        z -= atan_q30(n);
      end else begin
        t = x + (y >>> n);
        y = y - (x >>> n);
        z += atan_q30(n);
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic setpoint_t predict_setpoints(stick_event_t ev);
    setpoint_t r;
    longint e, rd, a, s, c, dp, yw, lim;
    r.controller_reset = 1'b0;
    case (ev.func)
      FUNC_NAV: begin
        e  = stick_to_rad(ev.elevator_pulse);
        rd = stick_to_rad(ev.rudder_pulse);
        a  = stick_to_rad(ev.aileron_pulse);
        roll_sin_cos(ev.roll_angle, s, c);
        // products in Q43, back to Q13 with round half up
        dp = (-c * e - s * rd + (longint'(1) << 29)) >>> 30;
        yw = (c * rd - s * e + (longint'(1) << 29)) >>> 30;
        lim = longint'(limit_cfg);
        pitch_sp = saturate(pitch_sp + dp, -lim, lim);
        roll_sp  = saturate(roll_sp + a, -lim, lim);
        yaw_sp   = saturate(yw, -32768, 32767);
        nav_count++;
      end
      FUNC_TAKEOVER: begin
        pitch_sp = longint'(ev.pitch_angle);
        roll_sp  = longint'(ev.roll_angle);
        yaw_sp   = 0;
        ctrl_en  = 1'b1;
        r.controller_reset = 1'b1;
        takeover_count++;
      end
      FUNC_RELEASE: begin
        ctrl_en = 1'b0;
        release_count++;
      end
      default: unused_count++;
    endcase
    r.pitch_target       = ANG_W'(pitch_sp);
    r.roll_target        = ANG_W'(roll_sp);
    r.yaw_target         = ANG_W'(yaw_sp);
    r.controller_enabled = ctrl_en;
    return r;
  endfunction

  // input driver; the expectation is formed when the transaction is taken
  stick_event_t cur_event;
  int  in_gap = 0;
  bit  in_burst = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_if.ready) begin
        setpoint_q.push_back(predict_setpoints(cur_event));
        in_gap = in_burst ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0)
          in_burst = !in_burst;
      end
      if (!in_valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          cur_event = event_q.pop_front();
          in_valid <= 1'b1;
          in_func  <= cur_event.func;
          in_roll  <= cur_event.roll_angle;
          in_pitch <= cur_event.pitch_angle;
          in_elev  <= cur_event.elevator_pulse;
          in_rud   <= cur_event.rudder_pulse;
          in_ail   <= cur_event.aileron_pulse;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int out_stall = 0;
  bit out_burst = 1'b0;

  always @(posedge clk) begin : result_check
    setpoint_t want;
    if (rst_n) begin
      if (out_if.valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          report_error("result transaction with no event outstanding");
        end else begin
          want = setpoint_q.pop_front();
          checked_count++;
          if (out_if.pitch_target !== want.pitch_target)
            report_error($sformatf("pitch_target got %0d expected %0d",
                                   out_if.pitch_target, want.pitch_target));
          if (out_if.roll_target !== want.roll_target)
            report_error($sformatf("roll_target got %0d expected %0d",
                                   out_if.roll_target, want.roll_target));
          if (out_if.yaw_target !== want.yaw_target)
            report_error($sformatf("yaw_target got %0d expected %0d",
                                   out_if.yaw_target, want.yaw_target));
          if (out_if.controller_enabled !== want.controller_enabled)
            report_error($sformatf("controller_enabled got %b expected %b",
                                   out_if.controller_enabled, want.controller_enabled));
          if (out_if.controller_reset !== want.controller_reset)
            report_error($sformatf("controller_reset got %b expected %b",
                                   out_if.controller_reset, want.controller_reset));
        end
        out_stall = out_burst ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0)
          out_burst = !out_burst;
        if (out_stall != 0)
          out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (out_stall > 0)
          out_stall--;
        if (out_stall == 0)
          out_ready <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_if.ready) || (out_if.valid && out_ready) ||
          (cfg_valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[%0t] timeout: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  task automatic push_event(logic [FUNC_W-1:0] func, logic signed [ANG_W-1:0] roll,
                            logic signed [ANG_W-1:0] pitch, logic [PULSE_W-1:0] elev,
                            logic [PULSE_W-1:0] rud, logic [PULSE_W-1:0] ail);
    stick_event_t ev;
    ev.func           = func;
    ev.roll_angle     = roll;
    ev.pitch_angle    = pitch;
    ev.elevator_pulse = elev;
    ev.rudder_pulse   = rud;
    ev.aileron_pulse  = ail;
    event_q.push_back(ev);
  endtask

  // pulses spread over full range, dead band edges, near centre and the rails
  function automatic logic [PULSE_W-1:0] draw_pulse();
    int c, db, p;
    c  = int'(center_cfg);
    db = int'(dband_cfg);
    case ($urandom_range(0, 3))
      0:       p = int'($urandom_range(0, 4095));
      1:       p = c + ($urandom_range(0, 1) ? db : -db) + int'($urandom_range(0, 2)) - 1;
      2:       p = c + int'($urandom_range(0, 1200)) - 600;
      default: p = $urandom_range(0, 1) ? 4095 : 0;
    endcase
    if (p < 0)
      p = 0;
    if (p > 4095)
      p = 4095;
    return PULSE_W'(p);
  endfunction

  task automatic push_random_event();
    logic [FUNC_W-1:0]       func;
    logic signed [ANG_W-1:0] roll;
    int                      k;
    k = $urandom_range(0, 99);
    if (k < 70)
      func = FUNC_NAV;
    else if (k < 82)
      func = FUNC_TAKEOVER;
    else if (k < 92)
      func = FUNC_RELEASE;
    else
      func = FUNC_UNUSED;
    if ($urandom_range(0, 1))
      roll = ANG_W'($urandom);
    else
      roll = ANG_W'(int'($urandom_range(0, 25736)) - 12868);
    push_event(func, roll, ANG_W'($urandom), draw_pulse(), draw_pulse(), draw_pulse());
  endtask

  task automatic drain();
    while (event_q.size() != 0 || in_valid || setpoint_q.size() != 0)
      @(posedge clk);
  endtask

  // all three registers back to back; valid only drops after the last one
  task automatic write_settings(logic [PULSE_W-1:0] center, logic [DB_W-1:0] db,
                                logic [LIM_W-1:0] lim);
    logic [CFG_DATA_W-1:0] vals[3];
    logic [CFG_IDX_W-1:0]  idx;
    int                    n;
    vals[0] = CFG_DATA_W'(center);
    vals[1] = CFG_DATA_W'(db);
    vals[2] = CFG_DATA_W'(lim);
    @(posedge clk);
    for (n = 0; n < 3; n++) begin
      idx = CFG_IDX_W'(n);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[n];
      do @(posedge clk); while (!cfg_if.ready);
      case (idx)
        CFG_SERVO_CENTER: center_cfg = vals[n][PULSE_W-1:0];
        CFG_DEAD_BAND:    dband_cfg  = vals[n][DB_W-1:0];
        CFG_ANGLE_LIMIT:  limit_cfg  = vals[n][LIM_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic random_phase(logic [PULSE_W-1:0] center, logic [DB_W-1:0] db,
                              logic [LIM_W-1:0] lim);
    int n;
    write_settings(center, db, lim);
    for (n = 0; n < RAND_PER_SETTING; n++)
      push_random_event();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values: centre 1500, dead band 50, limit 60 deg
    push_event(FUNC_NAV, 0, 0, 1500, 1500, 1500);          // navigate while disabled
    push_event(FUNC_NAV, 0, 0, 1549, 1451, 1549);          // just inside dead band
    push_event(FUNC_NAV, 0, 0, 1550, 1450, 1550);          // on the dead band edge
    push_event(FUNC_NAV, 12868, 0, 4095, 0, 4095);
    push_event(FUNC_NAV, -12868, 0, 0, 4095, 0);
    push_event(FUNC_TAKEOVER, -32768, 32767, 1500, 1500, 1500);  // beyond limit
    push_event(FUNC_NAV, 32767, 0, 1500, 1500, 1500);      // saturates the loaded attitude
    push_event(FUNC_NAV, 25736, -1, 4095, 4095, 4095);     // roll near pi
    push_event(FUNC_NAV, -25736, 0, 0, 0, 0);
    push_event(FUNC_NAV, -32768, 0, 4095, 0, 2048);
    push_event(FUNC_UNUSED, 5, -5, 4095, 0, 4095);
    push_event(FUNC_RELEASE, 100, 100, 0, 4095, 0);        // setpoints kept
    push_event(FUNC_NAV, 1000, 0, 3000, 200, 2600);
    push_event(FUNC_TAKEOVER, 0, 0, 0, 0, 0);
    push_event(FUNC_NAV, 0, 0, 1500, 1500, 4095);
    push_event(FUNC_NAV, 0, 0, 1500, 1500, 4095);
    push_event(FUNC_NAV, 0, 0, 1500, 1500, 0);
    push_event(FUNC_NAV, 0, 0, 1500, 1500, 0);
    push_event(FUNC_NAV, 0, 0, 1500, 1500, 0);
    push_event(FUNC_TAKEOVER, 8579, -8579, 1500, 1500, 1500);
    push_event(FUNC_RELEASE, 0, 0, 1500, 1500, 1500);
    push_event(FUNC_RELEASE, -1, -1, 4095, 4095, 4095);
    push_event(FUNC_UNUSED, -32768, 32767, 0, 0, 0);
    drain();

    random_phase(0, 0, 0);
    random_phase(4095, 1023, 32767);
    random_phase(1500, 0, 8579);           // zero dead band
    random_phase(PULSE_W'($urandom_range(1000, 2000)), DB_W'($urandom_range(0, 200)),
                 LIM_W'($urandom_range(0, 32767)));
    random_phase(CENTER_RST, DB_RST, LIM_RST);

    repeat (40) @(posedge clk);
    $display("Covered %0d events: %0d navigate, %0d takeover, %0d release, %0d unused code,",
             nav_count + takeover_count + release_count + unused_count, nav_count,
             takeover_count, release_count, unused_count);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             settings_count, checked_count, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### stick_to_attitude_setpoint_core.f
src/stas_pkg.sv
src/stas_in_if.sv
src/stas_out_if.sv
src/stas_cfg_if.sv
src/stas_mul.sv
src/stas_cordic.sv
src/stick_to_attitude_setpoint_core.sv
src/stas_checker.sv
tb/testbench.sv
